@@ rtl/ssc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_pkg
// Types, command codes and the shape pattern function shared by the
// shape stamp canvas controller, datapath and top level.
// ----------------------------------------------------------------------------
package ssc_pkg;

   // Field widths of one request word and one response word.
   localparam int FUNC_W     = 4;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 6;
   localparam int ROW_BITS_W = 64;

   // Command codes.
   localparam logic [FUNC_W-1:0] FUNC_RECT     = 4'd0;
   localparam logic [FUNC_W-1:0] FUNC_TRIANGLE = 4'd1;
   localparam logic [FUNC_W-1:0] FUNC_RING     = 4'd2;
   localparam logic [FUNC_W-1:0] FUNC_DIAGONAL = 4'd3;
   localparam logic [FUNC_W-1:0] FUNC_DIAMOND  = 4'd4;
   localparam logic [FUNC_W-1:0] FUNC_X        = 4'd5;
   localparam logic [FUNC_W-1:0] FUNC_FILL     = 4'd6;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 4'd7;
   localparam logic [FUNC_W-1:0] FUNC_READ     = 4'd8;

   // A row pattern covers column offsets DX_MIN .. DX_MIN+PAT_W-1 from the
   // anchor column; bit b stands for offset b+DX_MIN.
   localparam int PAT_W  = 14;
   localparam int DX_MIN = -4;

   // Row offsets from the anchor row that any shape can touch.
   localparam int DY_W = 5;
   localparam logic signed [DY_W-1:0] DY_FIRST = -5'sd3;
   localparam logic signed [DY_W-1:0] DY_LAST  = 5'sd7;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ROW_W-1:0]  anchor_row;
      logic [COL_W-1:0]  anchor_col;
   } req_type;

   typedef struct packed {
      logic [ROW_BITS_W-1:0] row_bits;
      logic                  bad_command;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // latch the request word, row offset to first
      logic step;       // advance to the next row offset
      logic rd_issue;   // read the addressed canvas row
      logic wr_row;     // write the merged row back
      logic clear_all;  // blank the whole canvas
   } ssc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_bad;
      logic is_clear;
      logic is_read;
      logic row_ok;     // current row is on the canvas and gets cells
      logic last_row;   // current row offset is the last one
   } ssc_status_type;

   // Cells of one shape in the row at offset dy from the anchor row.
   function automatic logic [PAT_W-1:0] shape_pattern(
      input logic [FUNC_W-1:0]       func,
      input logic signed [DY_W-1:0]  dy
   );
      int          y;
      int          dx;
      int          ax;
      int          d2;
      logic [PAT_W-1:0] pat;
      y   = int'(dy);
      pat = '0;
      for (int b = 0; b < PAT_W; b++) begin
         dx = b + DX_MIN;
         ax = (dx < 0) ? -dx : dx;
         d2 = dx * dx + y * y;
         case (func)
            FUNC_RECT: begin
               pat[b] = (y >= 0) && (y <= 4) && (dx >= 0) && (dx <= 9) &&
                        ((y == 0) || (y == 4) || (dx == 0) || (dx == 9));
            end
            FUNC_FILL: begin
               pat[b] = (y >= 0) && (y <= 4) && (dx >= 0) && (dx <= 9);
            end
            FUNC_TRIANGLE: begin
               pat[b] = (y >= 0) && (y <= 4) && (ax <= y);
            end
            FUNC_RING: begin
               pat[b] = (y >= -3) && (y <= 3) && (ax <= 3) && (d2 >= 7) && (d2 <= 11);
            end
            FUNC_DIAGONAL: begin
               pat[b] = (y >= 0) && (y <= 7) && (dx == y);
            end
            FUNC_DIAMOND: begin
               pat[b] = ((y >= 0) && (y <= 3) && (ax <= y)) ||
                        ((y == 4) && (ax <= 1)) ||
                        ((y == 5) && (dx == 0));
            end
            FUNC_X: begin
               pat[b] = (y >= 0) && (y <= 6) && ((dx == y) || (dx == 6 - y));
            end
            default: begin
               pat[b] = 1'b0;
            end
         endcase
      end
      return pat;
   endfunction

endpackage
`default_nettype wire

@@ rtl/ssc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_ctrl
// Command sequencer: decodes the latched word and walks the shape rows,
// one read-modify-write per row that gets cells, then strobes the response.
// ----------------------------------------------------------------------------
module ssc_ctrl
   import ssc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   output      logic           busy,
   output      logic           rsp_valid,
   output      ssc_cmd_type    cmd,
   input  wire ssc_status_type status
);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_DECODE    = 5'b00010,
      ST_ROW_CHECK = 5'b00100,
      ST_ROW_WRITE = 5'b01000,
      ST_RESPOND   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_bad) begin
               state_in = ST_RESPOND;
            end else if (status.is_clear) begin
               cmd.clear_all = 1'b1;
               state_in      = ST_RESPOND;
            end else if (status.is_read) begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_RESPOND;
            end else begin
               state_in = ST_ROW_CHECK;
            end
         end
         ST_ROW_CHECK: begin
            if (status.row_ok) begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_ROW_WRITE;
            end else if (status.last_row) begin
               state_in = ST_RESPOND;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_ROW_WRITE: begin
            cmd.wr_row = 1'b1;
            if (status.last_row) begin
               state_in = ST_RESPOND;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_ROW_CHECK;
            end
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESPOND);

endmodule
`default_nettype wire

@@ rtl/ssc_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_datapath
// Canvas memory with per-row valid bits, the latched command word, the row
// offset counter, the shape mask shifter and the response word.
// ----------------------------------------------------------------------------
module ssc_datapath
   import ssc_pkg::*;
#(
   parameter int CANVAS_ROWS = 32,
   parameter int CANVAS_COLS = 64
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire req_type        req_item,
   input  wire ssc_cmd_type    cmd,
   output      ssc_status_type status,
   output      rsp_type        rsp_item
);

   localparam int RA = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
   localparam int TW = ((RA > ROW_W) ? RA : ROW_W) + 3;
   localparam int SW = CANVAS_COLS + PAT_W;
   localparam int OFS = -DX_MIN;
   localparam logic [TW-1:0] ROWS_LIM = TW'(CANVAS_ROWS);

   // Canvas storage; a row whose valid bit is low reads as blank.
   logic [CANVAS_COLS-1:0] canvas_mem [CANVAS_ROWS];
   logic [CANVAS_ROWS-1:0] valid_ff;
   logic [CANVAS_ROWS-1:0] valid_in;

   logic [FUNC_W-1:0]      func_ff,   func_in;
   logic [ROW_W-1:0]       row_ff,    row_in;
   logic [COL_W-1:0]       col_ff,    col_in;
   logic signed [DY_W-1:0] dy_ff,     dy_in;
   logic [CANVAS_COLS-1:0] rd_data_ff;
   logic                   rd_valid_ff;

   logic signed [TW-1:0]   target;
   logic                   target_ok;
   logic                   read_ok;
   logic [RA-1:0]          addr;
   logic [PAT_W-1:0]       pattern;
   logic [SW-1:0]          shifted;
   logic [CANVAS_COLS-1:0] mask;
   logic [CANVAS_COLS-1:0] old_row;
   logic [CANVAS_COLS-1:0] merged;

   // Latched word and row offset counter.
   always_comb begin
      func_in = func_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      dy_in   = dy_ff;
      if (cmd.load) begin
         func_in = req_item.func;
         row_in  = req_item.anchor_row;
         col_in  = req_item.anchor_col;
         dy_in   = DY_FIRST;
      end else if (cmd.step) begin
         dy_in = dy_ff + DY_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      dy_ff   <= dy_in;
   end

   // Target row and its address.
   assign target    = $signed({{(TW-ROW_W){1'b0}}, row_ff}) + TW'(dy_ff);
   assign target_ok = !target[TW-1] && (unsigned'(target) < ROWS_LIM);
   assign read_ok   = (TW'(row_ff) < ROWS_LIM);

   always_comb begin
      if (func_ff == FUNC_READ) begin
         addr = RA'(TW'(row_ff));
      end else begin
         addr = RA'(unsigned'(target));
      end
   end

   // Shape mask for the current row, clipped to the canvas columns.
   assign pattern = shape_pattern(func_ff, dy_ff);
   assign shifted = SW'(pattern) << col_ff;
   assign mask    = shifted[CANVAS_COLS+OFS-1:OFS];
   assign old_row = rd_valid_ff ? rd_data_ff : '0;
   assign merged  = old_row | mask;

   // Valid bits: reset and clear blank the canvas, a write marks its row.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_all) begin
         valid_in = '0;
      end else if (cmd.wr_row) begin
         valid_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Canvas memory, one row port, registered read.
   always_ff @(posedge clock) begin
      if (cmd.wr_row) begin
         canvas_mem[addr] <= merged;
      end
      if (cmd.rd_issue) begin
         rd_data_ff  <= canvas_mem[addr];
         rd_valid_ff <= valid_ff[addr];
      end
   end

   // Status toward the controller.
   always_comb begin
      status.is_bad   = !(func_ff inside {[FUNC_RECT:FUNC_READ]});
      status.is_clear = (func_ff == FUNC_CLEAR);
      status.is_read  = (func_ff == FUNC_READ);
      status.row_ok   = target_ok && (pattern != '0);
      status.last_row = (dy_ff == DY_LAST);
   end

   // Response word, valid while the controller strobes it.
   always_comb begin
      rsp_item.bad_command = status.is_bad;
      if (status.is_read && read_ok && rd_valid_ff) begin
         rsp_item.row_bits = ROW_BITS_W'(rd_data_ff);
      end else begin
         rsp_item.row_bits = '0;
      end
   end

endmodule
`default_nettype wire

@@ rtl/shape_stamp_canvas_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// shape_stamp_canvas_unit
// One-bit-per-cell canvas that stamps shapes, clears, and reads back rows.
// ----------------------------------------------------------------------------
//   channel   ports                 direction  flow
//   request   start, busy, req_item in         taken when start and not busy
//   response  rsp_valid, rsp_item   out        one-cycle strobe, no stall
//
// A shape word is answered once the controller has walked eleven row
// offsets: a row that gets no cells is only checked, and a row that gets
// cells takes a read-modify-write through the single canvas memory port.
// Clear, read and undefined words are answered right after decoding.
// The next word is taken the cycle after the response strobe; reset blanks
// the canvas at once through per-row valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
module shape_stamp_canvas_unit
   import ssc_pkg::*;
#(
   parameter int CANVAS_ROWS = 32,
   parameter int CANVAS_COLS = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_item,
   output      logic    rsp_valid,
   output      rsp_type rsp_item
);

   ssc_cmd_type    cmd;
   ssc_status_type status;

   // Sequencer.
   ssc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // Canvas and shape datapath.
   ssc_datapath #(
      .CANVAS_ROWS (CANVAS_ROWS),
      .CANVAS_COLS (CANVAS_COLS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shape stamp canvas unit. A short table of
// command words exercises every shape at the canvas edges, clear, row reads
// and undefined codes. It is followed by about a thousand random words in
// three phases of sender gaps. Every response word is checked field by
// field against a typed entry or an in-bench image stamping the same shapes.
// ----------------------------------------------------------------------------
module tb;
   import ssc_pkg::*;

   localparam int CANVAS_ROWS  = 32;
   localparam int CANVAS_COLS  = 64;
   localparam int RANDOM_WORDS = 1025;
   localparam int REPORT_LIMIT = 20;

   // One row of the directed table; typed rows carry their own response.
   typedef struct {
      req_type cmd;
      logic    typed;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   logic [CANVAS_COLS-1:0] canvas_img [CANVAS_ROWS];
   rsp_type                awaited_words [$];
   stim_row_type           directed_rows [$];

   int fail_count;
   int n_stamps;
   int n_reads;
   int n_clears;
   int n_undefined;

   shape_stamp_canvas_unit #(
      .CANVAS_ROWS(CANVAS_ROWS),
      .CANVAS_COLS(CANVAS_COLS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   // Clock with a 2 ns period.
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Set one cell of the canvas image; cells off the canvas are dropped.
   function automatic void mark_cell(input int r, input int c);
      if (r >= 0 && r < CANVAS_ROWS && c >= 0 && c < CANVAS_COLS) begin
         canvas_img[r][c] = 1'b1;
      end
   endfunction

   function automatic void mark_span(input int r, input int c0, input int c1);
      for (int c = c0; c <= c1; c++) begin
         mark_cell(r, c);
      end
   endfunction

   // Apply one command word to the canvas image and return its response.
   function automatic rsp_type canvas_apply(input req_type cmd);
      rsp_type res;
      int      r;
      int      c;
      int      d2;
      res = '0;
      r   = int'(cmd.anchor_row);
      c   = int'(cmd.anchor_col);
      case (cmd.func)
         FUNC_RECT, FUNC_FILL: begin
            for (int i = 0; i < 5; i++) begin
               for (int j = 0; j < 10; j++) begin
                  if (cmd.func == FUNC_FILL || i == 0 || i == 4 || j == 0 || j == 9) begin
                     mark_cell(r + i, c + j);
                  end
               end
            end
         end
         FUNC_TRIANGLE: begin
            for (int i = 0; i < 5; i++) begin
               mark_span(r + i, c - i, c + i);
            end
         end
         FUNC_RING: begin
            for (int dy = -3; dy <= 3; dy++) begin
               for (int dx = -3; dx <= 3; dx++) begin
                  d2 = dx * dx + dy * dy;
                  if (d2 >= 7 && d2 <= 11) begin
                     mark_cell(r + dy, c + dx);
                  end
               end
            end
         end
         FUNC_DIAGONAL: begin
            for (int i = 0; i < 8; i++) begin
               mark_cell(r + i, c + i);
            end
         end
         FUNC_DIAMOND: begin
            // Widening top half, then the narrowing tail below it.
            for (int i = 0; i < 4; i++) begin
               mark_span(r + i, c - i, c + i);
            end
            for (int i = 2; i >= 0; i--) begin
               mark_span(r + 5 - i, c - i, c + i);
            end
         end
         FUNC_X: begin
            for (int i = 0; i < 7; i++) begin
               mark_cell(r + i, c + i);
               mark_cell(r + i, c + 6 - i);
            end
         end
         FUNC_CLEAR: begin
            for (int k = 0; k < CANVAS_ROWS; k++) begin
               canvas_img[k] = '0;
            end
         end
         FUNC_READ: begin
            if (r < CANVAS_ROWS) begin
               res.row_bits = canvas_img[r];
            end
         end
         default: begin
            res.bad_command = 1'b1;
         end
      endcase
      return res;
   endfunction

   function automatic void add_row(input logic [FUNC_W-1:0] f, input int r, input int c,
                                   input logic typed, input logic [ROW_BITS_W-1:0] bits,
                                   input logic bad);
      stim_row_type row;
      row.cmd.func       = f;
      row.cmd.anchor_row = ROW_W'(r);
      row.cmd.anchor_col = COL_W'(c);
      row.typed          = typed;
      row.want.row_bits  = bits;
      row.want.bad_command = bad;
      directed_rows.push_back(row);
   endfunction

   // Keep start low for a number of cycles, with noise on the request bus.
   task automatic hold_off(input int cycles);
      @(negedge clock);
      start    <= 1'b0;
      req_item <= req_type'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Offer one word until it is taken, then record what it should return.
   task automatic issue_word(input req_type cmd, input logic typed, input rsp_type want);
      rsp_type predicted;
      @(negedge clock);
      start    <= 1'b1;
      req_item <= cmd;
      do @(posedge clock); while (busy);
      predicted = canvas_apply(cmd);
      awaited_words.push_back(typed ? want : predicted);
      case (cmd.func)
         FUNC_CLEAR: n_clears++;
         FUNC_READ:  n_reads++;
         default: begin
            if (cmd.func > FUNC_READ) begin
               n_undefined++;
            end else begin
               n_stamps++;
            end
         end
      endcase
   endtask

   // Response checker: every strobe must match the oldest expectation.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_words.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
               $display("%0t: response word with none expected: row_bits %h bad %b",
                        $time, rsp_item.row_bits, rsp_item.bad_command);
            end
         end else begin
            want = awaited_words.pop_front();
            if (rsp_item.row_bits !== want.row_bits) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("%0t: row_bits mismatch: expected %h actual %h",
                           $time, want.row_bits, rsp_item.row_bits);
               end
            end
            if (rsp_item.bad_command !== want.bad_command) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("%0t: bad_command mismatch: expected %b actual %b",
                           $time, want.bad_command, rsp_item.bad_command);
               end
            end
         end
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   // Main sequence.
   initial begin : stimulus
      req_type     cmd;
      int          gap_pct;
      int          pick;
      rsp_type     none;
      logic [ROW_BITS_W-1:0] top_bit;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      none        = '0;
      fail_count  = 0;
      n_stamps    = 0;
      n_reads     = 0;
      n_clears    = 0;
      n_undefined = 0;
      top_bit     = '0;
      top_bit[CANVAS_COLS-1] = 1'b1;
      for (int k = 0; k < CANVAS_ROWS; k++) begin
         canvas_img[k] = '0;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: blank canvas, undefined codes, every shape clipped at
      // an edge with reads of the rows it hits, then clear, corner fill and one more undefined code.
      add_row(FUNC_READ,          0,  0, 1'b1, '0, 1'b0);
      add_row(FUNC_READ,         31, 63, 1'b1, '0, 1'b0);
      add_row(FUNC_READ + 4'd1,   0,  0, 1'b1, '0, 1'b1);
      add_row(FUNC_READ + 4'd7,  31, 63, 1'b1, '0, 1'b1);
      add_row(FUNC_RECT,          0,  0, 1'b0, '0, 1'b0);
      add_row(FUNC_READ,          0,  0, 1'b0, '0, 1'b0);
      add_row(FUNC_READ,          4,  0, 1'b0, '0, 1'b0);
      add_row(FUNC_FILL,         29, 55, 1'b0, '0, 1'b0);
      add_row(FUNC_READ,         31,  0, 1'b0, '0, 1'b0);
      add_row(FUNC_TRIANGLE,      0,  0, 1'b0, '0, 1'b0);
      add_row(FUNC_READ,          2, 17, 1'b0, '0, 1'b0);
      add_row(FUNC_RING,          1, 62, 1'b0, '0, 1'b0);
      add_row(FUNC_READ,          0, 40, 1'b0, '0, 1'b0);
      add_row(FUNC_DIAGONAL,     28, 60, 1'b0, '0, 1'b0);
      add_row(FUNC_READ,         31,  5, 1'b0, '0, 1'b0);
      add_row(FUNC_DIAMOND,      10,  2, 1'b0, '0, 1'b0);
      add_row(FUNC_READ,         13,  0, 1'b0, '0, 1'b0);
      add_row(FUNC_X,            26, 58, 1'b0, '0, 1'b0);
      add_row(FUNC_READ,         30, 63, 1'b0, '0, 1'b0);
      add_row(FUNC_CLEAR,        21, 42, 1'b1, '0, 1'b0);
      add_row(FUNC_READ,          0,  0, 1'b1, '0, 1'b0);
      add_row(FUNC_READ,         31,  0, 1'b1, '0, 1'b0);
      add_row(FUNC_FILL,         31, 63, 1'b0, '0, 1'b0);
      add_row(FUNC_READ,         31,  0, 1'b1, top_bit, 1'b0);
      add_row(FUNC_READ + 4'd4,  10, 21, 1'b1, '0, 1'b1);
      foreach (directed_rows[i]) begin
         issue_word(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
      end

      // Random words in three phases: sender gaps at 37 in 100, then at 75,
      // then back to back. Reads are frequent so stamps are seen; clears are
      // rare enough to let shapes pile up and overlap.
      for (int phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 37 : (phase == 1) ? 75 : 0;
         for (int n = 0; n < (RANDOM_WORDS + 2) / 3; n++) begin
            if ($urandom_range(99) < gap_pct) begin
               hold_off($urandom_range(1, 12));
            end
            cmd  = req_type'($urandom);
            pick = $urandom_range(99);
            if (pick < 40) begin
               cmd.func = FUNC_READ;
            end else if (pick < 43) begin
               cmd.func = FUNC_CLEAR;
            end else if (pick < 48) begin
               cmd.func = FUNC_W'($urandom_range(FUNC_READ + 1, (1 << FUNC_W) - 1));
            end else begin
               cmd.func = FUNC_W'($urandom_range(FUNC_RECT, FUNC_FILL));
            end
            issue_word(cmd, 1'b0, none);
         end
      end

      @(negedge clock);
      start <= 1'b0;

      // Drain, then leave room for any stray strobe.
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Covered %0d command words: %0d stamps, %0d row reads, %0d clears, %0d undefined.",
               n_stamps + n_reads + n_clears + n_undefined, n_stamps, n_reads, n_clears,
               n_undefined);
      $display("Sender gaps at 37 and 75 in 100, then none; %0d field mismatches seen.",
               fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
